// ===== rtl/phs_pkg.sv =====
// ----------------------------------------------------------------------------
// phs_pkg
// Shared types and constants of the priority heap scheduler: field widths,
// the heap entry record, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package phs_pkg;

	localparam int HEAP_DEPTH_DEF = 32;

	localparam int KIND_W   = 1;
	localparam int ID_W     = 16;
	localparam int TIME_W   = 24;
	localparam int PRIO_W   = 8;
	localparam int BURST_W  = 16;
	localparam int STATUS_W = 3;
	localparam int QUEUED_W = 6;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic [KIND_W-1:0] KIND_ENQUEUE = 1'b0;
	localparam logic [KIND_W-1:0] KIND_STEP    = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]    proc_id;
		logic [TIME_W-1:0]  arrival;
		logic [PRIO_W-1:0]  prio;
		logic [BURST_W-1:0] burst;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [STATUS_W-1:0] {
		ST_ENQUEUED   = 3'd0,
		ST_FUTURE     = 3'd1,
		ST_FULL       = 3'd2,
		ST_IDLE_TICK  = 3'd3,
		ST_DISPATCHED = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_UP_RD,
		S_UP_CMP,
		S_POP_LD,
		S_T_MAX,
		S_T_ADD,
		S_T_TAT,
		S_DN_RD,
		S_DN_CMP,
		S_PUT,
		S_DONE
	} state_t;

endpackage

// ===== rtl/phs_cmd_if.sv =====
// ----------------------------------------------------------------------------
// phs_cmd_if
// Command channel: enqueue or scheduling step, valid/ready handshake.
// ----------------------------------------------------------------------------
interface phs_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [phs_pkg::KIND_W-1:0]   kind;
	logic [phs_pkg::ID_W-1:0]     proc_id;
	logic [phs_pkg::TIME_W-1:0]   arrival;
	logic [phs_pkg::PRIO_W-1:0]   prio;
	logic [phs_pkg::BURST_W-1:0]  burst;

	modport source (output valid, kind, proc_id, arrival, prio, burst, input ready);
	modport sink   (input valid, kind, proc_id, arrival, prio, burst, output ready);
endinterface

// ===== rtl/phs_res_if.sv =====
// ----------------------------------------------------------------------------
// phs_res_if
// Result channel: one beat per command, valid/ready handshake.
// ----------------------------------------------------------------------------
interface phs_res_if;
	logic                          valid;
	logic                          ready;
	logic [phs_pkg::STATUS_W-1:0]  status;
	logic [phs_pkg::ID_W-1:0]      done_id;
	logic [phs_pkg::TIME_W-1:0]    done_arrival;
	logic [phs_pkg::BURST_W-1:0]   done_burst;
	logic [phs_pkg::TIME_W-1:0]    completion;
	logic [phs_pkg::TIME_W-1:0]    turnaround;
	logic [phs_pkg::TIME_W-1:0]    waiting;
	logic [phs_pkg::TIME_W-1:0]    response;
	logic [phs_pkg::TIME_W-1:0]    now_time;
	logic [phs_pkg::QUEUED_W-1:0]  queued;

	modport source (output valid, status, done_id, done_arrival, done_burst, completion,
		turnaround, waiting, response, now_time, queued, input ready);
	modport sink   (input valid, status, done_id, done_arrival, done_burst, completion,
		turnaround, waiting, response, now_time, queued, output ready);
endinterface

// ===== rtl/phs_heap_ram.sv =====
// ----------------------------------------------------------------------------
// phs_heap_ram
// Heap entry store: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module phs_heap_ram #(
	parameter int  DEPTH = phs_pkg::HEAP_DEPTH_DEF,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  phs_pkg::entry_t      wdata,
	input  logic [AW-1:0]        raddr0,
	input  logic [AW-1:0]        raddr1,
	output phs_pkg::entry_t      rdata0,
	output phs_pkg::entry_t      rdata1
);

	phs_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

// ===== rtl/priority_heap_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_heap_scheduler
// Non-preemptive priority scheduler on a binary max-heap held in RAM.
// ----------------------------------------------------------------------------
// One command is worked at a time; cmd.ready is high only while the sequencer
// waits for a command. The heap sits in a RAM with one write and two
// registered read ports, and each heap level takes a read state, then a
// compare-and-move state. An enqueue makes one parent compare per level it
// rises, plus the failing one when it stops below the root; in a dispatch the
// last entry sinks at most log2(HEAP_DEPTH) levels; a refused enqueue or an
// idle tick goes straight from decode to the result. A result waits in an
// output register, so the next command is taken while it is still held; the
// result register frees up the sequencer only when the previous beat has left.
// ----------------------------------------------------------------------------
module priority_heap_scheduler #(
	parameter int HEAP_DEPTH = phs_pkg::HEAP_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	phs_cmd_if.sink    cmd,
	phs_res_if.source  res
);

	localparam int AW = $clog2(HEAP_DEPTH);
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int XW = AW + 2;

	phs_pkg::state_t  state_q, state_d;
	logic [CW-1:0]    count_q;
	logic [phs_pkg::TIME_W-1:0] clk_q;
	logic             res_valid_q;

	logic [phs_pkg::KIND_W-1:0] kind_q;
	phs_pkg::entry_t  item_q;
	phs_pkg::entry_t  mov_q;
	phs_pkg::entry_t  root_q;
	logic [AW-1:0]    pos_q;
	logic [phs_pkg::TIME_W-1:0] tat_q;
	phs_pkg::status_t status_q;

	phs_pkg::status_t             res_status_q;
	logic [phs_pkg::ID_W-1:0]     res_id_q;
	logic [phs_pkg::TIME_W-1:0]   res_arr_q;
	logic [phs_pkg::BURST_W-1:0]  res_bst_q;
	logic [phs_pkg::TIME_W-1:0]   res_comp_q;
	logic [phs_pkg::TIME_W-1:0]   res_tat_q;
	logic [phs_pkg::TIME_W-1:0]   res_wt_q;
	logic [phs_pkg::TIME_W-1:0]   res_now_q;
	logic [phs_pkg::QUEUED_W-1:0] res_queued_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	phs_pkg::entry_t  ram_wdata;
	logic [AW-1:0]    ram_raddr0;
	logic [AW-1:0]    ram_raddr1;
	phs_pkg::entry_t  rd0;
	phs_pkg::entry_t  rd1;

	logic [AW-1:0]    parent;
	logic [XW-1:0]    lidx;
	logic [XW-1:0]    ridx;
	logic [XW-1:0]    count_x;
	logic             arr_late;
	logic             full;
	logic             up_swap;
	logic             l_win;
	logic             r_win;
	logic             out_free;
	logic             load_out;
	logic [phs_pkg::TIME_W:0]   time_sum;
	logic [phs_pkg::TIME_W-1:0] bst_x;
	logic [phs_pkg::TIME_W-1:0] wt;
	logic             is_disp;

	phs_heap_ram #(
		.DEPTH (HEAP_DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr0 (ram_raddr0),
		.raddr1 (ram_raddr1),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	assign parent   = (pos_q - AW'(1)) >> 1;
	assign lidx     = {1'b0, pos_q, 1'b1};
	assign ridx     = lidx + XW'(1);
	assign count_x  = XW'(count_q);
	assign arr_late = item_q.arrival > clk_q;
	assign full     = count_q == CW'(HEAP_DEPTH);
	assign up_swap  = rd0.prio < mov_q.prio;
	assign l_win    = (lidx < count_x) && (rd0.prio > mov_q.prio);
	assign r_win    = (ridx < count_x) && (rd1.prio > (l_win ? rd0.prio : mov_q.prio));
	assign out_free = !res_valid_q || res.ready;
	assign load_out = (state_q == phs_pkg::S_DONE) && out_free;
	assign time_sum = {1'b0, clk_q} + (phs_pkg::TIME_W + 1)'(root_q.burst);
	assign bst_x    = phs_pkg::TIME_W'(root_q.burst);
	assign wt       = (tat_q > bst_x) ? (tat_q - bst_x) : '0;
	assign is_disp  = status_q == phs_pkg::ST_DISPATCHED;

	always_comb begin
		state_d    = state_q;
		ram_we     = 1'b0;
		ram_waddr  = pos_q;
		ram_wdata  = mov_q;
		ram_raddr0 = '0;
		ram_raddr1 = '0;
		case (state_q)
			phs_pkg::S_IDLE: begin
				if (cmd.valid) state_d = phs_pkg::S_DECODE;
			end
			phs_pkg::S_DECODE: begin
				if (kind_q == phs_pkg::KIND_ENQUEUE) begin
					if (arr_late || full) state_d = phs_pkg::S_DONE;
					else if (count_q == '0) state_d = phs_pkg::S_PUT;
					else state_d = phs_pkg::S_UP_RD;
				end else if (count_q == '0) begin
					state_d = phs_pkg::S_DONE;
				end else begin
					ram_raddr1 = AW'(count_q - CW'(1));
					state_d    = phs_pkg::S_POP_LD;
				end
			end
			phs_pkg::S_UP_RD: begin
				ram_raddr0 = parent;
				state_d    = phs_pkg::S_UP_CMP;
			end
			phs_pkg::S_UP_CMP: begin
				if (up_swap) begin
					ram_we    = 1'b1;
					ram_wdata = rd0;
					state_d   = (parent == '0) ? phs_pkg::S_PUT : phs_pkg::S_UP_RD;
				end else begin
					state_d = phs_pkg::S_PUT;
				end
			end
			phs_pkg::S_POP_LD: state_d = phs_pkg::S_T_MAX;
			phs_pkg::S_T_MAX:  state_d = phs_pkg::S_T_ADD;
			phs_pkg::S_T_ADD:  state_d = phs_pkg::S_T_TAT;
			phs_pkg::S_T_TAT:  state_d = phs_pkg::S_DN_RD;
			phs_pkg::S_DN_RD: begin
				ram_raddr0 = lidx[AW-1:0];
				ram_raddr1 = ridx[AW-1:0];
				state_d    = phs_pkg::S_DN_CMP;
			end
			phs_pkg::S_DN_CMP: begin
				if (r_win) begin
					ram_we    = 1'b1;
					ram_wdata = rd1;
					state_d   = phs_pkg::S_DN_RD;
				end else if (l_win) begin
					ram_we    = 1'b1;
					ram_wdata = rd0;
					state_d   = phs_pkg::S_DN_RD;
				end else begin
					state_d = phs_pkg::S_PUT;
				end
			end
			phs_pkg::S_PUT: begin
				ram_we  = 1'b1;
				state_d = phs_pkg::S_DONE;
			end
			phs_pkg::S_DONE: begin
				if (out_free) state_d = phs_pkg::S_IDLE;
			end
			default: state_d = phs_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= phs_pkg::S_IDLE;
			count_q     <= '0;
			clk_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
			case (state_q)
				phs_pkg::S_DECODE: begin
					if (kind_q == phs_pkg::KIND_STEP && count_q == '0
						&& clk_q != phs_pkg::TIME_MAX) begin
						clk_q <= clk_q + phs_pkg::TIME_W'(1);
					end
				end
				phs_pkg::S_POP_LD: count_q <= count_q - CW'(1);
				phs_pkg::S_T_MAX: begin
					if (clk_q < root_q.arrival) clk_q <= root_q.arrival;
				end
				phs_pkg::S_T_ADD: begin
					clk_q <= time_sum[phs_pkg::TIME_W] ? phs_pkg::TIME_MAX
						: time_sum[phs_pkg::TIME_W-1:0];
				end
				phs_pkg::S_PUT: begin
					if (kind_q == phs_pkg::KIND_ENQUEUE) count_q <= count_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			phs_pkg::S_IDLE: begin
				if (cmd.valid) begin
					kind_q         <= cmd.kind;
					item_q.proc_id <= cmd.proc_id;
					item_q.arrival <= cmd.arrival;
					item_q.prio    <= cmd.prio;
					item_q.burst   <= cmd.burst;
				end
			end
			phs_pkg::S_DECODE: begin
				pos_q <= AW'(count_q);
				mov_q <= item_q;
				if (kind_q == phs_pkg::KIND_ENQUEUE) begin
					if (arr_late) status_q <= phs_pkg::ST_FUTURE;
					else if (full) status_q <= phs_pkg::ST_FULL;
					else status_q <= phs_pkg::ST_ENQUEUED;
				end else if (count_q == '0) begin
					status_q <= phs_pkg::ST_IDLE_TICK;
				end else begin
					status_q <= phs_pkg::ST_DISPATCHED;
				end
			end
			phs_pkg::S_UP_CMP: begin
				if (up_swap) pos_q <= parent;
			end
			phs_pkg::S_POP_LD: begin
				root_q <= rd0;
				mov_q  <= rd1;
				pos_q  <= '0;
			end
			phs_pkg::S_T_TAT: tat_q <= clk_q - root_q.arrival;
			phs_pkg::S_DN_CMP: begin
				if (r_win) pos_q <= ridx[AW-1:0];
				else if (l_win) pos_q <= lidx[AW-1:0];
			end
			phs_pkg::S_DONE: begin
				if (out_free) begin
					res_status_q <= status_q;
					res_id_q     <= is_disp ? root_q.proc_id : '0;
					res_arr_q    <= is_disp ? root_q.arrival : '0;
					res_bst_q    <= is_disp ? root_q.burst : '0;
					res_comp_q   <= is_disp ? clk_q : '0;
					res_tat_q    <= is_disp ? tat_q : '0;
					res_wt_q     <= is_disp ? wt : '0;
					res_now_q    <= clk_q;
					res_queued_q <= phs_pkg::QUEUED_W'(count_q);
				end
			end
			default: ;
		endcase
	end

	assign cmd.ready        = state_q == phs_pkg::S_IDLE;
	assign res.valid        = res_valid_q;
	assign res.status       = res_status_q;
	assign res.done_id      = res_id_q;
	assign res.done_arrival = res_arr_q;
	assign res.done_burst   = res_bst_q;
	assign res.completion   = res_comp_q;
	assign res.turnaround   = res_tat_q;
	assign res.waiting      = res_wt_q;
	assign res.response     = res_wt_q;
	assign res.now_time     = res_now_q;
	assign res.queued       = res_queued_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(HEAP_DEPTH))
		else $error("heap count above depth");

	a_time_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> clk_q >= $past(clk_q))
		else $error("system time went backward");

	a_enq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && status_q == phs_pkg::ST_ENQUEUED |-> count_q != '0)
		else $error("enqueue reported with empty heap");

	a_comp_after_arrival: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_status_q == phs_pkg::ST_DISPATCHED |-> res_comp_q >= res_arr_q)
		else $error("completion before arrival");

endmodule
